// ===== src/ole_pkg.sv =====
// Shared types and constants for the ordered list engine.
`default_nettype none
package ole_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [CNT_W-1:0]         cnt_type;

   typedef enum logic [2:0] {
      REQ_INSERT     = 3'd0,
      REQ_PUSH_FRONT = 3'd1,
      REQ_PUSH_BACK  = 3'd2,
      REQ_DROP_LAST  = 3'd3,
      REQ_REMOVE     = 3'd4,
      REQ_CLEAR      = 3'd5
   } req_code_type;

   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_ABSENT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_APPLY,
      S_RESULT
   } state_type;

   typedef enum logic [1:0] {
      AP_NONE,
      AP_SHIFT_IN,
      AP_SHIFT_OUT,
      AP_LOAD_TAIL
   } apply_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic      start;
      logic      ins_mode;
      logic      use_pass;
      apply_type apply;
      data_type  value;
      cnt_type   count;
      idx_type   last_idx;
      logic      nonempty;
   } cell_cmd_type;

   // Per-cell search result.
   typedef struct packed {
      logic hit;
      logic miss;
   } cell_stat_type;

endpackage
`default_nettype wire

// ===== src/ole_cell.sv =====
// One slot of the list: holds a value and takes part in the search wave.
`default_nettype none
module ole_cell (
   input  wire                   clock,
   input  wire                   reset,
   input  ole_pkg::cell_cmd_type cmd,
   input  ole_pkg::idx_type      idx,
   input  wire                   left_tok,
   input  wire                   left_pass,
   input  ole_pkg::data_type     left_val,
   input  ole_pkg::data_type     right_val,
   output logic                  tok_out,
   output logic                  pass_out,
   output ole_pkg::data_type     val_out,
   output ole_pkg::cell_stat_type stat,
   output ole_pkg::data_type     tail_val
);
   import ole_pkg::*;

   logic     tok_ff, tok_in;
   logic     pass_ff, pass_in;
   data_type val_ff, val_in;
   logic     occ, gt, eq, stop, eff_pass, left_eff;

   always_comb begin
      occ  = CNT_W'(idx) < cmd.count;
      gt   = $signed(val_ff) > $signed(cmd.value);
      eq   = val_ff == cmd.value;
      stat.hit  = tok_ff & (cmd.ins_mode ? (!occ | gt) : (occ & eq));
      stat.miss = tok_ff & !cmd.ins_mode & !occ;
      stop    = stat.hit | stat.miss;
      tok_out = tok_ff & !stop;
      tok_in  = left_tok;
      // A cell the search wave passed without stopping lies before the edit point.
      if (cmd.start) begin
         pass_in = 1'b0;
      end else if (tok_ff && !stop) begin
         pass_in = 1'b1;
      end else begin
         pass_in = pass_ff;
      end
      eff_pass = cmd.use_pass & pass_ff;
      left_eff = (idx == '0) | (cmd.use_pass & left_pass);
      val_in   = val_ff;
      unique case (cmd.apply)
         AP_SHIFT_IN: begin
            if (!eff_pass) val_in = left_eff ? cmd.value : left_val;
         end
         AP_SHIFT_OUT: begin
            if (!eff_pass) val_in = right_val;
         end
         AP_LOAD_TAIL: begin
            if (CNT_W'(idx) == cmd.count) val_in = cmd.value;
         end
         AP_NONE: begin
            val_in = val_ff;
         end
         default: begin
            val_in = val_ff;
         end
      endcase
      tail_val = (cmd.nonempty && idx == cmd.last_idx) ? val_ff : '0;
      pass_out = pass_ff;
      val_out  = val_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff  <= 1'b0;
         pass_ff <= 1'b0;
      end else begin
         tok_ff  <= tok_in;
         pass_ff <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule
`default_nettype wire

// ===== src/ordered_list_engine.sv =====
// Top level of the ordered list engine: controller and the row of list cells.
`default_nettype none
// The list lives in a row of cells, one value per cell, kept packed in list
// order. Insert in order and remove send a search token down the row one
// cell per cycle, and a remove that finds no equal entry skips the edit step.
// Push front, push back, drop last and clear go straight to the edit step;
// requests that are refused or unused go straight to the result. One request
// is worked on at a time; a new request is taken while the previous result
// still waits on the response side. No clearing sweep is needed after reset.
module ordered_list_engine (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire  [2:0]             req_type,
   input  ole_pkg::data_type      req_value,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output logic [1:0]             rsp_status,
   output ole_pkg::cnt_type       rsp_count,
   output ole_pkg::data_type      rsp_first_value,
   output ole_pkg::data_type      rsp_last_value
);
   import ole_pkg::*;

   state_type    state_ff, state_in;
   logic [2:0]   op_ff;
   data_type     value_ff;
   cnt_type      count_ff, count_in;
   status_type   status_ff, status_in;
   logic         rsp_valid_ff;
   logic [1:0]   rsp_status_ff;
   cnt_type      rsp_count_ff;
   data_type     rsp_first_ff, rsp_last_ff;

   cell_cmd_type  cmd;
   logic          accept, rsp_load, full, empty, need_scan, unused_code;
   logic          hit_any, miss_any;
   logic          tok_vec  [CAPACITY];
   logic          pass_vec [CAPACITY];
   data_type      val_vec  [CAPACITY];
   data_type      tail_vec [CAPACITY];
   cell_stat_type stat_vec [CAPACITY];
   data_type      last_val;

   // Request decode.
   always_comb begin
      full        = count_ff == CNT_W'(CAPACITY);
      empty       = count_ff == '0;
      need_scan   = 1'b0;
      unused_code = 1'b0;
      status_in   = ST_DONE;
      unique case (req_type)
         REQ_INSERT: begin
            if (full) status_in = ST_FULL;
            else      need_scan = 1'b1;
         end
         REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
            if (full) status_in = ST_FULL;
         end
         REQ_DROP_LAST: begin
            if (empty) status_in = ST_EMPTY;
         end
         REQ_REMOVE: begin
            if (empty) status_in = ST_EMPTY;
            else       need_scan = 1'b1;
         end
         REQ_CLEAR: begin
            status_in = ST_DONE;
         end
         default: begin
            unused_code = 1'b1;
         end
      endcase
   end

   always_comb begin
      hit_any  = 1'b0;
      miss_any = 1'b0;
      last_val = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit_any  = hit_any | stat_vec[i].hit;
         miss_any = miss_any | stat_vec[i].miss;
         last_val = last_val | tail_vec[i];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (status_in != ST_DONE || unused_code) state_in = S_RESULT;
               else if (need_scan)                      state_in = S_SCAN;
               else                                     state_in = S_APPLY;
            end
         end
         S_SCAN: begin
            if (hit_any)                                               state_in = S_APPLY;
            else if (miss_any || (tok_vec[CAPACITY-1] && !cmd.ins_mode)) state_in = S_RESULT;
         end
         S_APPLY: begin
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      req_stall    = state_ff != S_IDLE;
      accept       = req_valid & !req_stall;
      rsp_load     = (state_ff == S_RESULT) & (!rsp_valid_ff | !rsp_stall);
      cmd.start    = accept & need_scan;
      cmd.ins_mode = op_ff == REQ_INSERT;
      cmd.use_pass = op_ff != REQ_PUSH_FRONT;
      cmd.apply    = AP_NONE;
      cmd.value    = value_ff;
      cmd.count    = count_ff;
      cmd.last_idx = IDX_W'(count_ff - CNT_W'(1));
      cmd.nonempty = count_ff != '0;
      count_in     = count_ff;
      if (state_ff == S_APPLY) begin
         unique case (op_ff)
            REQ_INSERT, REQ_PUSH_FRONT: begin
               cmd.apply = AP_SHIFT_IN;
               count_in  = count_ff + CNT_W'(1);
            end
            REQ_PUSH_BACK: begin
               cmd.apply = AP_LOAD_TAIL;
               count_in  = count_ff + CNT_W'(1);
            end
            REQ_REMOVE: begin
               cmd.apply = AP_SHIFT_OUT;
               count_in  = count_ff - CNT_W'(1);
            end
            REQ_DROP_LAST: begin
               count_in = count_ff - CNT_W'(1);
            end
            REQ_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_type;
         value_ff  <= req_value;
         status_ff <= status_in;
      end else if (state_ff == S_SCAN && !hit_any &&
                   (miss_any || (tok_vec[CAPACITY-1] && !cmd.ins_mode))) begin
         status_ff <= ST_ABSENT;
      end
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= count_ff;
         rsp_first_ff  <= (count_ff != '0) ? val_vec[0] : '0;
         rsp_last_ff   <= last_val;
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic     l_tok, l_pass;
      data_type l_val, r_val;
      if (g == 0) begin : g_first
         assign l_tok  = cmd.start;
         assign l_pass = 1'b1;
         assign l_val  = '0;
      end else begin : g_mid
         assign l_tok  = tok_vec[g-1];
         assign l_pass = pass_vec[g-1];
         assign l_val  = val_vec[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign r_val = '0;
      end else begin : g_inner
         assign r_val = val_vec[g+1];
      end
      ole_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .idx       (IDX_W'(g)),
         .left_tok  (l_tok),
         .left_pass (l_pass),
         .left_val  (l_val),
         .right_val (r_val),
         .tok_out   (tok_vec[g]),
         .pass_out  (pass_vec[g]),
         .val_out   (val_vec[g]),
         .stat      (stat_vec[g]),
         .tail_val  (tail_vec[g])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_count       = rsp_count_ff;
   assign rsp_first_value = rsp_first_ff;
   assign rsp_last_value  = rsp_last_ff;

endmodule
`default_nettype wire
